// File: rtl/emr_pkg.sv
package emr_pkg;

   localparam int MEMBERS      = 8;
   localparam int DATA_WIDTH   = 32;
   localparam int RESULT_WIDTH = DATA_WIDTH + 3;
   localparam int CNT_W        = 4;
   localparam int SEL_W        = 3;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 4;
   // reciprocal division: q = (mag * ceil(2^RECIP_SHIFT / n)) >> RECIP_SHIFT,
   // exact for any magnitude below 2^RESULT_WIDTH and n up to 8
   localparam int RECIP_SHIFT  = RESULT_WIDTH + 3;
   localparam int RECIP_W      = RECIP_SHIFT + 1;
   localparam int MAG_LO_W     = 18;
   localparam int MAG_HI_W     = RESULT_WIDTH - MAG_LO_W;
   localparam int PLO_W        = MAG_LO_W + RECIP_W;
   localparam int PHI_W        = MAG_HI_W + RECIP_W;
   localparam int PROD_W       = RESULT_WIDTH + RECIP_W;

   typedef enum logic [2:0] {
      MODE_SUM     = 3'd0,
      MODE_MEAN    = 3'd1,
      MODE_ANOMALY = 3'd2,
      MODE_MIN     = 3'd3,
      MODE_MAX     = 3'd4,
      MODE_SELECT  = 3'd5
   } mode_type;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SEL  = 2'd2;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] member_0;
      logic signed [DATA_WIDTH-1:0] member_1;
      logic signed [DATA_WIDTH-1:0] member_2;
      logic signed [DATA_WIDTH-1:0] member_3;
      logic signed [DATA_WIDTH-1:0] member_4;
      logic signed [DATA_WIDTH-1:0] member_5;
      logic signed [DATA_WIDTH-1:0] member_6;
      logic signed [DATA_WIDTH-1:0] member_7;
      logic signed [DATA_WIDTH-1:0] prior_value;
      logic                         last_point;
   } req_type;

   typedef struct packed {
      logic signed [RESULT_WIDTH-1:0] result;
      logic                           last_out;
   } rsp_type;

   // effective configuration, already clamped
   typedef struct packed {
      mode_type         mode;
      logic [CNT_W-1:0] count;
      logic [SEL_W-1:0] sel;
   } cfg_type;

   // reduction results handed from the tree to the divider
   typedef struct packed {
      logic signed [RESULT_WIDTH-1:0] acc;
      logic signed [DATA_WIDTH-1:0]   extreme;
      logic signed [DATA_WIDTH-1:0]   picked;
      logic signed [DATA_WIDTH-1:0]   prior;
      logic                           last;
      mode_type                       mode;
      logic [CNT_W-1:0]               count;
   } red_type;

   function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
      logic [RECIP_W-1:0] r;
      case (n)
         4'd2:    r = 39'd137438953472;
         4'd3:    r = 39'd91625968982;
         4'd4:    r = 39'd68719476736;
         4'd5:    r = 39'd54975581389;
         4'd6:    r = 39'd45812984491;
         4'd7:    r = 39'd39268272421;
         4'd8:    r = 39'd34359738368;
         default: r = 39'd274877906944;
      endcase
      return r;
   endfunction

endpackage

// File: rtl/emr_cfg.sv
module emr_cfg import emr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output cfg_type               cfg
);

   mode_type         mode_ff;
   logic [CNT_W-1:0] num_ff;
   logic [SEL_W-1:0] sel_ff;
   logic [CNT_W-1:0] count;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_SUM;
         num_ff  <= CNT_W'(MEMBERS);
         sel_ff  <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MODE: mode_ff <= mode_type'(csr_data[2:0]);
            CSR_NUM:  num_ff  <= csr_data;
            CSR_SEL:  sel_ff  <= csr_data[SEL_W-1:0];
            default:  ;
         endcase
      end
   end

   // zero counts as one member, anything above the lane count saturates
   always_comb begin
      if (num_ff == '0) begin
         count = CNT_W'(1);
      end else if (num_ff > CNT_W'(MEMBERS)) begin
         count = CNT_W'(MEMBERS);
      end else begin
         count = num_ff;
      end
      cfg.mode  = mode_ff;
      cfg.count = count;
      if (CNT_W'(sel_ff) >= count) begin
         cfg.sel = SEL_W'(count - CNT_W'(1));
      end else begin
         cfg.sel = sel_ff;
      end
   end

endmodule

// File: rtl/emr_tree.sv
module emr_tree import emr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    in_valid,
   output logic    in_ready,
   input  req_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output red_type out_data
);

   localparam int L1 = MEMBERS / 2;
   localparam int L2 = MEMBERS / 4;

   logic signed [DATA_WIDTH-1:0] lane [MEMBERS];

   // stage 1
   logic                         v1_ff;
   logic signed [DATA_WIDTH:0]   sum1_ff [L1];
   logic signed [DATA_WIDTH:0]   sum1_in [L1];
   logic signed [DATA_WIDTH-1:0] ext1_ff [L1];
   logic signed [DATA_WIDTH-1:0] ext1_in [L1];
   red_type                      c1_ff;
   red_type                      c1_in;
   // stage 2
   logic                         v2_ff;
   logic signed [DATA_WIDTH+1:0] sum2_ff [L2];
   logic signed [DATA_WIDTH+1:0] sum2_in [L2];
   logic signed [DATA_WIDTH-1:0] ext2_ff [L2];
   logic signed [DATA_WIDTH-1:0] ext2_in [L2];
   red_type                      c2_ff;
   // stage 3
   logic                         v3_ff;
   red_type                      c3_ff;
   red_type                      c3_in;

   logic en1, en2, en3;

   assign en3      = !v3_ff || out_ready;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   assign lane[0] = in_data.member_0;
   assign lane[1] = in_data.member_1;
   assign lane[2] = in_data.member_2;
   assign lane[3] = in_data.member_3;
   assign lane[4] = in_data.member_4;
   assign lane[5] = in_data.member_5;
   assign lane[6] = in_data.member_6;
   assign lane[7] = in_data.member_7;

   // idle lanes add zero and repeat member 0 for min/max
   always_comb begin
      logic signed [DATA_WIDTH-1:0] sa, sb, ma, mb;
      for (int l = 0; l < L1; l++) begin
         sa = (CNT_W'(2*l)   < cfg.count) ? lane[2*l]   : '0;
         sb = (CNT_W'(2*l+1) < cfg.count) ? lane[2*l+1] : '0;
         ma = (CNT_W'(2*l)   < cfg.count) ? lane[2*l]   : lane[0];
         mb = (CNT_W'(2*l+1) < cfg.count) ? lane[2*l+1] : lane[0];
         sum1_in[l] = {sa[DATA_WIDTH-1], sa} + {sb[DATA_WIDTH-1], sb};
         if (cfg.mode == MODE_MIN) begin
            ext1_in[l] = (mb < ma) ? mb : ma;
         end else begin
            ext1_in[l] = (mb > ma) ? mb : ma;
         end
      end
      c1_in         = '0;
      c1_in.picked  = lane[cfg.sel];
      c1_in.prior   = in_data.prior_value;
      c1_in.last    = in_data.last_point;
      c1_in.mode    = cfg.mode;
      c1_in.count   = cfg.count;
   end

   always_comb begin
      for (int l = 0; l < L2; l++) begin
         sum2_in[l] = {sum1_ff[2*l][DATA_WIDTH], sum1_ff[2*l]}
                    + {sum1_ff[2*l+1][DATA_WIDTH], sum1_ff[2*l+1]};
         if (c1_ff.mode == MODE_MIN) begin
            ext2_in[l] = (ext1_ff[2*l+1] < ext1_ff[2*l]) ? ext1_ff[2*l+1] : ext1_ff[2*l];
         end else begin
            ext2_in[l] = (ext1_ff[2*l+1] > ext1_ff[2*l]) ? ext1_ff[2*l+1] : ext1_ff[2*l];
         end
      end
   end

   always_comb begin
      c3_in     = c2_ff;
      c3_in.acc = {sum2_ff[0][DATA_WIDTH+1], sum2_ff[0]}
                + {sum2_ff[1][DATA_WIDTH+1], sum2_ff[1]};
      if (c2_ff.mode == MODE_MIN) begin
         c3_in.extreme = (ext2_ff[1] < ext2_ff[0]) ? ext2_ff[1] : ext2_ff[0];
      end else begin
         c3_in.extreme = (ext2_ff[1] > ext2_ff[0]) ? ext2_ff[1] : ext2_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         sum1_ff <= sum1_in;
         ext1_ff <= ext1_in;
         c1_ff   <= c1_in;
      end
      if (en2) begin
         sum2_ff <= sum2_in;
         ext2_ff <= ext2_in;
         c2_ff   <= c1_ff;
      end
      if (en3) begin
         c3_ff <= c3_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_data  = c3_ff;

endmodule

// File: rtl/emr_div.sv
module emr_div import emr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  red_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   typedef struct packed {
      logic signed [RESULT_WIDTH-1:0] fixed;
      logic signed [DATA_WIDTH-1:0]   prior;
      logic                           last;
      mode_type                       mode;
      logic                           neg;
   } side_type;

   // stage 4: magnitude and reciprocal
   logic                      v4_ff;
   logic [RESULT_WIDTH-1:0]   mag_ff;
   logic [RESULT_WIDTH-1:0]   mag_in;
   logic [RECIP_W-1:0]        rcp_ff;
   side_type                  s4_ff;
   side_type                  s4_in;
   // stage 5: partial products
   logic                      v5_ff;
   logic [PLO_W-1:0]          plo_ff;
   logic [PLO_W-1:0]          plo_in;
   logic [PHI_W-1:0]          phi_ff;
   logic [PHI_W-1:0]          phi_in;
   side_type                  s5_ff;
   // stage 6: quotient magnitude
   logic                      v6_ff;
   logic [PROD_W-1:0]         prod;
   logic [RESULT_WIDTH-1:0]   quo_ff;
   side_type                  s6_ff;
   // stage 7: output register
   logic                      v7_ff;
   rsp_type                   out_ff;
   rsp_type                   out_in;

   logic en4, en5, en6, en7;

   assign en7      = !v7_ff || out_ready;
   assign en6      = !v6_ff || en7;
   assign en5      = !v5_ff || en6;
   assign en4      = !v4_ff || en5;
   assign in_ready = en4;

   always_comb begin
      s4_in.prior = in_data.prior;
      s4_in.last  = in_data.last;
      s4_in.mode  = in_data.mode;
      s4_in.neg   = in_data.acc[RESULT_WIDTH-1];
      mag_in      = s4_in.neg ? RESULT_WIDTH'(-in_data.acc) : RESULT_WIDTH'(in_data.acc);
      case (in_data.mode)
         MODE_SUM:             s4_in.fixed = in_data.acc;
         MODE_MIN, MODE_MAX:   s4_in.fixed = RESULT_WIDTH'(in_data.extreme);
         MODE_SELECT:          s4_in.fixed = RESULT_WIDTH'(in_data.picked);
         default:              s4_in.fixed = '0;
      endcase
   end

   assign plo_in = PLO_W'(mag_ff[MAG_LO_W-1:0]) * PLO_W'(rcp_ff);
   assign phi_in = PHI_W'(mag_ff[RESULT_WIDTH-1:MAG_LO_W]) * PHI_W'(rcp_ff);
   assign prod   = PROD_W'(plo_ff) + {phi_ff, {MAG_LO_W{1'b0}}};

   // mean truncates toward zero: apply the sign to the magnitude quotient
   always_comb begin
      logic signed [RESULT_WIDTH-1:0] pr;
      pr              = RESULT_WIDTH'(s6_ff.prior);
      out_in.last_out = s6_ff.last;
      case (s6_ff.mode)
         MODE_MEAN:    out_in.result = s6_ff.neg ? -quo_ff : quo_ff;
         MODE_ANOMALY: out_in.result = s6_ff.neg ? pr + quo_ff : pr - quo_ff;
         default:      out_in.result = s6_ff.fixed;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else begin
         if (en4) v4_ff <= in_valid;
         if (en5) v5_ff <= v4_ff;
         if (en6) v6_ff <= v5_ff;
         if (en7) v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         mag_ff <= mag_in;
         rcp_ff <= recip(in_data.count);
         s4_ff  <= s4_in;
      end
      if (en5) begin
         plo_ff <= plo_in;
         phi_ff <= phi_in;
         s5_ff  <= s4_ff;
      end
      if (en6) begin
         quo_ff <= prod[PROD_W-2:RECIP_SHIFT];
         s6_ff  <= s5_ff;
      end
      if (en7) begin
         out_ff <= out_in;
      end
   end

   assign out_valid = v7_ff;
   assign out_data  = out_ff;

endmodule

// File: rtl/ensemble_member_reduction.sv
// Ensemble member reduction: one grid point in, one reduced value out.
// Throughput: one item per cycle while rsp_stall is low; seven pipeline
// registers, each with its own valid bit, so bubbles close up and a stalled
// output still lets items in while any stage is empty. Reset: synchronous,
// active high; clears all valid bits and loads mode sum, eight members,
// selected member 0.
module ensemble_member_reduction import emr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // input items
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   // result items
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   // register writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type cfg;
   red_type red;
   logic    red_valid;
   logic    red_ready;
   logic    tree_ready;

   // registers are always writable; software must write them only while idle, the block does not enforce it
   assign csr_ready = 1'b1;

   // register file: holds mode, member count and selection, and clamps
   // count to 1..8 and selection to the active range
   emr_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // stages 1-3: masked lanes, pairwise sum and min/max tree, member pick
   emr_tree u_tree (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_valid),
      .in_ready  (tree_ready),
      .in_data   (req_data),
      .out_valid (red_valid),
      .out_ready (red_ready),
      .out_data  (red)
   );

   // stages 4-7: divide the sum by the member count through a reciprocal
   // multiply split in two partial products, then sign, anomaly and mode
   // select into the output register
   emr_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (red_valid),
      .in_ready  (red_ready),
      .in_data   (red),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .out_data  (rsp_data)
   );

   assign req_stall = !tree_ready;

endmodule

// File: rtl/emr_checker.sv
module emr_checker import emr_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // pipeline comes out of reset empty
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // with the output free the whole pipeline advances
   a_no_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("input stalled while output drains");

   // an empty output register never blocks the input
   a_empty_out: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty output");

endmodule

bind ensemble_member_reduction emr_checker u_emr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
